// ----- hw/rtl/ccbd_pkg.sv -----
// shared types and constants for the console cpu bus decoder
`timescale 1ns / 1ps

package ccbd_pkg;

  // item operations
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpLoad  = 2'd2;
  localparam logic [1:0] OpDma   = 2'd3;

  // result targets
  localparam logic [2:0] TgtRam  = 3'd0;
  localparam logic [2:0] TgtPpu  = 3'd1;
  localparam logic [2:0] TgtApu  = 3'd2;
  localparam logic [2:0] TgtPad  = 3'd3;
  localparam logic [2:0] TgtDma  = 3'd4;
  localparam logic [2:0] TgtCart = 3'd5;
  localparam logic [2:0] TgtNone = 3'd6;

  // address map
  localparam logic [15:0] AddrRamEnd   = 16'h1FFF;
  localparam logic [15:0] AddrPpuEnd   = 16'h3FFF;
  localparam logic [15:0] AddrApuEnd   = 16'h4013;
  localparam logic [15:0] AddrDmaStart = 16'h4014;
  localparam logic [15:0] AddrApuStat  = 16'h4015;
  localparam logic [15:0] AddrPad0     = 16'h4016;
  localparam logic [15:0] AddrPad1     = 16'h4017;
  localparam logic [15:0] AddrCartWr   = 16'h4020;
  localparam logic [15:0] AddrCartRd   = 16'h8000;
  localparam logic [15:0] RamMask      = 16'h07FF;

  localparam logic [9:0] DmaStall     = 10'd513;
  localparam logic [7:0] Pad1Mark     = 8'h40;
  localparam logic [7:0] DmaLastOffs  = 8'hFF;

  // one work ram access requested by the decode stage
  typedef struct packed {
    logic        we;
    logic        re;
    logic [15:0] addr;   // already masked to the mirror range
    logic [7:0]  wdata;
  } ram_req_t;

  // result of one item, before work ram read data is merged
  typedef struct packed {
    logic        from_ram;
    logic [7:0]  rdata;
    logic [2:0]  target;
    logic [15:0] fwd_address;
    logic [7:0]  fwd_data;
    logic        fwd_write;
    logic        oam_write;
    logic        dma_busy;
    logic [9:0]  stall_cycles;
  } res_t;

endpackage

// ----- hw/rtl/ccbd_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ccbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ccbd_ctrl.sv -----
// address decode, pad ports and sprite dma state
`timescale 1ns / 1ps

module ccbd_ctrl import ccbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  wdata_i,
  input  logic        pad_index_i,
  output res_t        res_o,
  output ram_req_t    ram_req_o
);

  logic [7:0] btn_q    [2];
  logic [7:0] btn_d    [2];
  logic [7:0] shift_q  [2];
  logic [7:0] shift_d  [2];
  logic       strobe_q [2];
  logic       strobe_d [2];
  logic       dma_on_q, dma_on_d;
  logic [7:0] page_q, page_d;
  logic [7:0] offset_q, offset_d;

  logic        rd_en;
  logic [15:0] rd_addr;
  logic        pad_sel;

  always_comb begin
    btn_d     = btn_q;
    shift_d   = shift_q;
    strobe_d  = strobe_q;
    dma_on_d  = dma_on_q;
    page_d    = page_q;
    offset_d  = offset_q;
    res_o        = '0;
    res_o.target = TgtNone;
    ram_req_o    = '0;
    rd_en        = 1'b0;
    rd_addr      = address_i;
    pad_sel      = 1'b0;

    case (op_i)
      OpRead: begin
        rd_en = 1'b1;
      end
      OpWrite: begin
        if (address_i <= AddrRamEnd) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.addr  = address_i & RamMask;
          ram_req_o.wdata = wdata_i;
          res_o.target    = TgtRam;
        end else if (address_i <= AddrApuEnd || address_i == AddrApuStat ||
                     address_i == AddrPad1) begin
          res_o.target      = (address_i <= AddrPpuEnd) ? TgtPpu : TgtApu;
          res_o.fwd_address = address_i;
          res_o.fwd_data    = wdata_i;
          res_o.fwd_write   = 1'b1;
        end else if (address_i == AddrDmaStart) begin
          page_d             = wdata_i;
          offset_d           = '0;
          dma_on_d           = 1'b1;
          res_o.target       = TgtDma;
          res_o.stall_cycles = DmaStall;
        end else if (address_i == AddrPad0) begin
          strobe_d[0] = wdata_i[0];
          strobe_d[1] = wdata_i[0];
          if (wdata_i[0]) begin
            shift_d[0] = btn_q[0];
            shift_d[1] = btn_q[1];
          end
          res_o.target = TgtPad;
        end else if (address_i >= AddrCartWr) begin
          res_o.target      = TgtCart;
          res_o.fwd_address = address_i;
          res_o.fwd_data    = wdata_i;
          res_o.fwd_write   = 1'b1;
        end
      end
      OpLoad: begin
        btn_d[pad_index_i] = wdata_i;
      end
      OpDma: begin
        if (dma_on_q) begin
          rd_en           = 1'b1;
          rd_addr         = {page_q, offset_q};
          res_o.oam_write = 1'b1;
          offset_d        = offset_q + 8'd1;
          if (offset_q == DmaLastOffs) begin
            dma_on_d = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // bus read, shared by cpu reads and dma steps
    if (rd_en) begin
      if (rd_addr <= AddrRamEnd) begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = rd_addr & RamMask;
        res_o.from_ram = 1'b1;
        res_o.target   = TgtRam;
      end else if (rd_addr <= AddrPpuEnd) begin
        res_o.target      = TgtPpu;
        res_o.fwd_address = rd_addr;
      end else if (rd_addr <= AddrApuEnd || rd_addr == AddrApuStat) begin
        res_o.target      = TgtApu;
        res_o.fwd_address = rd_addr;
      end else if (rd_addr == AddrPad0 || rd_addr == AddrPad1) begin
        pad_sel     = rd_addr[0];
        res_o.rdata = {7'd0, shift_q[pad_sel][0]} | (pad_sel ? Pad1Mark : 8'h00);
        if (!strobe_q[pad_sel]) begin
          shift_d[pad_sel] = {1'b1, shift_q[pad_sel][7:1]};
        end
        res_o.target = TgtPad;
      end else if (rd_addr >= AddrCartRd) begin
        res_o.target      = TgtCart;
        res_o.fwd_address = rd_addr;
      end
    end

    res_o.dma_busy = dma_on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q[0]    <= '0;
      btn_q[1]    <= '0;
      shift_q[0]  <= '0;
      shift_q[1]  <= '0;
      strobe_q[0] <= 1'b0;
      strobe_q[1] <= 1'b0;
      dma_on_q    <= 1'b0;
      page_q      <= '0;
      offset_q    <= '0;
    end else if (fire_i) begin
      btn_q    <= btn_d;
      shift_q  <= shift_d;
      strobe_q <= strobe_d;
      dma_on_q <= dma_on_d;
      page_q   <= page_d;
      offset_q <= offset_d;
    end
  end

endmodule

// ----- hw/rtl/console_cpu_bus_decoder.sv -----
// top level: input register, work ram with clearing pass, result register
//
// One item on the input channel is a cpu bus read or write, a load of one
// pad's button bits, or one step of a sprite dma. Every accepted item gives
// exactly one result transfer on the output channel, in order.
// A transfer happens when valid is high and stall is low.
// The item is decoded out of the input register and the work ram is
// addressed, and the result is then loaded into the result register once
// it is empty or the receiver is not stalling (the ram's registered read
// data is merged at the output). Throughput is one item per cycle while the
// receiver does not stall, set by the decode and the one ram access per item.
// After reset the 2048-byte work ram is cleared one byte per cycle, so the
// input is stalled until the clear ends; pads and dma state reset at once.
// When the receiver stalls, the result register holds, the input register
// fills behind it and then the input channel is stalled; with the result
// register empty, a new item is taken even while the receiver stalls.
// Forwarded picture, sound and cartridge reads give rdata zero and have
// their data merged outside the block.
`timescale 1ns / 1ps

module console_cpu_bus_decoder import ccbd_pkg::*; #(
  parameter int RAM_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  wdata_i,
  input  logic        pad_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  rdata_o,
  output logic [2:0]  target_o,
  output logic [15:0] fwd_address_o,
  output logic [7:0]  fwd_data_o,
  output logic        fwd_write_o,
  output logic        oam_write_o,
  output logic        dma_busy_o,
  output logic [9:0]  stall_cycles_o
);

  localparam int AW = $clog2(RAM_DEPTH);

  // input register
  logic        v1_q;
  logic [1:0]  op_q;
  logic [15:0] address_q;
  logic [7:0]  wdata_q;
  logic        pad_index_q;

  // result register
  logic        vo_q;
  res_t        res_q;

  logic        clear_q;
  logic [AW-1:0] clr_cnt_q;

  logic        adv1;
  logic        take_in;
  res_t        res_d;
  ram_req_t    ram_req;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;

  assign adv1       = v1_q && (!vo_q || !out_stall_i);
  assign take_in    = in_valid_i && !in_stall_o;
  assign in_stall_o = clear_q || (v1_q && !adv1);

  ccbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (adv1),
    .op_i        (op_q),
    .address_i   (address_q),
    .wdata_i     (wdata_q),
    .pad_index_i (pad_index_q),
    .res_o       (res_d),
    .ram_req_o   (ram_req)
  );

  // clearing pass owns the write port until it ends
  always_comb begin
    if (clear_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = adv1 && ram_req.we;
      ram_waddr = ram_req.addr[AW-1:0];
      ram_wdata = ram_req.wdata;
    end
  end

  ccbd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv1 && ram_req.re),
    .raddr_i (ram_req.addr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(RAM_DEPTH - 1)) begin
        clear_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (take_in) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        vo_q <= 1'b1;
      end else if (!out_stall_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q        <= op_i;
      address_q   <= address_i;
      wdata_q     <= wdata_i;
      pad_index_q <= pad_index_i;
    end
    if (adv1) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = vo_q;
  assign rdata_o        = res_q.from_ram ? ram_rdata : res_q.rdata;
  assign target_o       = res_q.target;
  assign fwd_address_o  = res_q.fwd_address;
  assign fwd_data_o     = res_q.fwd_data;
  assign fwd_write_o    = res_q.fwd_write;
  assign oam_write_o    = res_q.oam_write;
  assign dma_busy_o     = res_q.dma_busy;
  assign stall_cycles_o = res_q.stall_cycles;

  // no item may touch the ram while it is being cleared
  a_no_item_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> (in_stall_o && !adv1))
    else $error("item accepted during work ram clear");

  // a dma start reports the stall and leaves dma running
  a_dma_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o == TgtDma) |-> (stall_cycles_o == DmaStall && dma_busy_o))
    else $error("dma start without stall or busy");

  // only a dma start adds a cpu stall
  a_stall_only_dma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o != TgtDma) |-> (stall_cycles_o == '0))
    else $error("stall reported for a non dma transfer");

  // forwarded writes go only to external targets
  a_fwd_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fwd_write_o) |->
      (target_o == TgtPpu || target_o == TgtApu || target_o == TgtCart))
    else $error("forwarded write to an internal target");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the console cpu bus decoder
`timescale 1ns / 1ps

module testbench;
  import ccbd_pkg::*;

  localparam int RamDepth   = 2048;
  localparam int ItemTarget = 1050;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 120;
  localparam int TailCycles = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] address;
    logic [7:0]  wdata;
    logic        pad_index;
    logic        drain_first;  // wait for every outstanding result before offering
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [2:0]  target;
    logic [15:0] fwd_address;
    logic [7:0]  fwd_data;
    logic        fwd_write;
    logic        oam_write;
    logic        dma_busy;
    logic [9:0]  stall_cycles;
  } bus_result_t;

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;
  typedef enum logic [1:0] {SeqRam, SeqPad, SeqNoise, SeqDma} seq_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = OpRead;
  logic [15:0] address_i = '0;
  logic [7:0]  wdata_i = '0;
  logic        pad_index_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  rdata_o;
  logic [2:0]  target_o;
  logic [15:0] fwd_address_o;
  logic [7:0]  fwd_data_o;
  logic        fwd_write_o;
  logic        oam_write_o;
  logic        dma_busy_o;
  logic [9:0]  stall_cycles_o;

  console_cpu_bus_decoder #(.RAM_DEPTH(RamDepth)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .address_i, .wdata_i, .pad_index_i,
    .out_valid_o, .out_stall_i, .rdata_o, .target_o, .fwd_address_o, .fwd_data_o,
    .fwd_write_o, .oam_write_o, .dma_busy_o, .stall_cycles_o
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the bus state
  logic [7:0] ram_shadow [RamDepth];
  logic [7:0] pad_buttons_sh [2];
  logic [7:0] pad_shift_sh [2];
  logic       pad_strobe_sh [2];
  logic       xfer_on_sh;
  logic [7:0] src_pg_sh;
  logic [7:0] src_offs_sh;

  bus_access_t access_queue [$];
  bus_result_t expected_bus_results [$];

  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_reads = 0, n_writes = 0, n_loads = 0, n_dma_steps = 0, n_dma_starts = 0;
  int n_dma_done = 0, n_pad_reads = 0;
  int cycle_count = 0;

  function automatic void shadow_rd(input logic [15:0] a, inout bus_result_t r);
    logic p;
    p = a[0];
    if (a <= AddrRamEnd) begin
      r.rdata = ram_shadow[11'(a & RamMask)];
      r.target = TgtRam;
    end else if (a <= AddrPpuEnd) begin
      r.target = TgtPpu;
      r.fwd_address = a;
    end else if (a <= AddrApuEnd || a == AddrApuStat) begin
      r.target = TgtApu;
      r.fwd_address = a;
    end else if (a == AddrPad0 || a == AddrPad1) begin
      r.rdata = {7'b0, pad_shift_sh[p][0]} | (p ? Pad1Mark : 8'h00);
      if (!pad_strobe_sh[p]) pad_shift_sh[p] = {1'b1, pad_shift_sh[p][7:1]};
      r.target = TgtPad;
      n_pad_reads++;
    end else if (a >= AddrCartRd) begin
      r.target = TgtCart;
      r.fwd_address = a;
    end else begin
      r.target = TgtNone;
    end
  endfunction

  function automatic void shadow_wr(input logic [15:0] a, input logic [7:0] d,
                                    inout bus_result_t r);
    if (a <= AddrRamEnd) begin
      ram_shadow[11'(a & RamMask)] = d;
      r.target = TgtRam;
    end else if (a <= AddrApuEnd || a == AddrApuStat || a == AddrPad1) begin
      r.target = (a <= AddrPpuEnd) ? TgtPpu : TgtApu;
      r.fwd_address = a;
      r.fwd_data = d;
      r.fwd_write = 1'b1;
    end else if (a == AddrDmaStart) begin
      src_pg_sh = d;
      src_offs_sh = 8'h00;
      xfer_on_sh = 1'b1;
      r.target = TgtDma;
      r.stall_cycles = DmaStall;
      n_dma_starts++;
    end else if (a == AddrPad0) begin
      pad_strobe_sh[0] = d[0];
      pad_strobe_sh[1] = d[0];
      if (d[0]) begin
        pad_shift_sh[0] = pad_buttons_sh[0];
        pad_shift_sh[1] = pad_buttons_sh[1];
      end
      r.target = TgtPad;
    end else if (a >= AddrCartWr) begin
      r.target = TgtCart;
      r.fwd_address = a;
      r.fwd_data = d;
      r.fwd_write = 1'b1;
    end else begin
      r.target = TgtNone;
    end
  endfunction

  // advance the shadow state by one accepted access and queue its result
  function automatic void decode_access(input bus_access_t acc);
    bus_result_t r;
    r = '0;
    r.target = TgtNone;
    case (acc.op)
      OpRead: begin
        shadow_rd(acc.address, r);
        n_reads++;
      end
      OpWrite: begin
        shadow_wr(acc.address, acc.wdata, r);
        n_writes++;
      end
      OpLoad: begin
        pad_buttons_sh[acc.pad_index] = acc.wdata;
        n_loads++;
      end
      default: begin
        if (xfer_on_sh) begin
          shadow_rd({src_pg_sh, src_offs_sh}, r);
          r.oam_write = 1'b1;
          src_offs_sh = src_offs_sh + 8'd1;
          n_dma_steps++;
          if (src_offs_sh == 8'h00) begin
            xfer_on_sh = 1'b0;
            n_dma_done++;
          end
        end
      end
    endcase
    r.dma_busy = xfer_on_sh;
    expected_bus_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  task automatic add_access(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] data, input logic pad, input logic drain);
    bus_access_t acc;
    acc.op = op;
    acc.address = addr;
    acc.wdata = data;
    acc.pad_index = pad;
    acc.drain_first = drain;
    access_queue.push_back(acc);
  endtask

  task automatic add_noise(input logic drain);
    logic [15:0] addr;
    addr = $urandom_range(0, 1) ? 16'($urandom()) : 16'h4000 + 16'($urandom_range(0, 31));
    add_access(2'($urandom_range(0, 3)), addr, 8'($urandom()), 1'($urandom_range(0, 1)), drain);
  endtask

  // driver: bursts of transfers separated by random gaps
  bus_access_t cur_access;
  int  burst_left = 0;
  int  gap_left = 0;
  logic fire;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= OpRead;
      address_i <= '0;
      wdata_i <= '0;
      pad_index_i <= 1'b0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        decode_access(cur_access);
        n_accepted <= n_accepted + 1;
      end
      if (fire || !in_valid_i) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (access_queue.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (access_queue[0].drain_first &&
                     (n_accepted + (fire ? 1 : 0)) != n_checked) begin
          in_valid_i <= 1'b0;
        end else begin
          cur_access = access_queue.pop_front();
          op_i <= cur_access.op;
          address_i <= cur_access.address;
          wdata_i <= cur_access.wdata;
          pad_index_i <= cur_access.pad_index;
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // monitor: checks each result transfer and drives the receiver stall pattern
  stall_mode_e stall_mode = StallNone;
  int  mode_left = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;
  bus_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bus_results.size() == 0) begin
          $error("result transfer with nothing expected: target %0d", target_o);
          n_errors++;
        end else begin
          want = expected_bus_results.pop_front();
          check_field("rdata", 16'(want.rdata), 16'(rdata_o));
          check_field("target", 16'(want.target), 16'(target_o));
          check_field("fwd_address", want.fwd_address, fwd_address_o);
          check_field("fwd_data", 16'(want.fwd_data), 16'(fwd_data_o));
          check_field("fwd_write", 16'(want.fwd_write), 16'(fwd_write_o));
          check_field("oam_write", 16'(want.oam_write), 16'(oam_write_o));
          check_field("dma_busy", 16'(want.dma_busy), 16'(dma_busy_o));
          check_field("stall_cycles", 16'(want.stall_cycles), 16'(stall_cycles_o));
        end
        n_checked <= n_checked + 1;
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && n_checked >= 400) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
          StallNone:  out_stall_i <= 1'b0;
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall_i <= ($urandom_range(0, 9) < 7);
          default:    out_stall_i <= (cycle_count % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, n_checked, n_accepted);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    seq_kind_e   kind;
    logic [15:0] ram_addrs [$];
    logic [15:0] a;
    logic [7:0]  page;
    int          n;
    int          steps;
    logic        drain;
    logic        first_seq;

    for (int i = 0; i < RamDepth; i++) ram_shadow[i] = 8'h00;
    for (int i = 0; i < 2; i++) begin
      pad_buttons_sh[i] = 8'h00;
      pad_shift_sh[i] = 8'h00;
      pad_strobe_sh[i] = 1'b0;
    end
    xfer_on_sh = 1'b0;
    src_pg_sh = 8'h00;
    src_offs_sh = 8'h00;

    // directed: map edges, mirrors, pad strobe behavior, dma idle/start/restart
    add_access(OpWrite, 16'h0000, 8'hFF, 1'b0, 1'b0);
    add_access(OpRead,  16'h1800, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, 16'h1FFF, 8'hA5, 1'b1, 1'b0);
    add_access(OpRead,  16'h07FF, 8'h00, 1'b0, 1'b0);
    add_access(OpRead,  16'h2000, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, 16'h3FFF, 8'h5A, 1'b0, 1'b0);
    add_access(OpRead,  16'h4000, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, 16'h4013, 8'h81, 1'b0, 1'b0);
    add_access(OpRead,  AddrApuStat, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, AddrApuStat, 8'h0F, 1'b0, 1'b0);
    add_access(OpWrite, AddrPad1, 8'hC0, 1'b0, 1'b0);
    add_access(OpRead,  AddrDmaStart, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, 16'h4018, 8'h77, 1'b0, 1'b0);
    add_access(OpWrite, 16'h401F, 8'h00, 1'b0, 1'b0);
    add_access(OpRead,  16'h7FFF, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, AddrCartWr, 8'h3C, 1'b0, 1'b0);
    add_access(OpRead,  16'hFFFF, 8'h00, 1'b0, 1'b0);
    add_access(OpLoad,  16'h0000, 8'h5A, 1'b0, 1'b0);
    add_access(OpLoad,  16'hFFFF, 8'hC3, 1'b1, 1'b0);
    add_access(OpWrite, AddrPad0, 8'h01, 1'b0, 1'b0);
    add_access(OpRead,  AddrPad0, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, AddrPad0, 8'hFE, 1'b0, 1'b0);
    add_access(OpRead,  AddrPad0, 8'h00, 1'b0, 1'b0);
    add_access(OpRead,  AddrPad1, 8'h00, 1'b0, 1'b0);
    add_access(OpDma,   16'h0000, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, AddrDmaStart, 8'h00, 1'b0, 1'b0);
    add_access(OpDma,   16'h0000, 8'h00, 1'b0, 1'b0);
    add_access(OpDma,   16'h0000, 8'h00, 1'b0, 1'b0);
    add_access(OpWrite, AddrDmaStart, 8'h40, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) add_access(OpDma, 16'h0000, 8'h00, 1'b0, 1'b0);

    // random sequences, the first a full dma that waits for the pipeline to drain
    first_seq = 1'b1;
    while (access_queue.size() < ItemTarget) begin
      drain = first_seq || ($urandom_range(0, 9) == 0);
      if (first_seq) kind = SeqDma;
      else begin
        n = $urandom_range(0, 5);
        kind = (n < 2) ? SeqRam : (n < 4) ? SeqPad : (n == 4) ? SeqNoise : SeqDma;
      end
      case (kind)
        SeqRam: begin
          ram_addrs.delete();
          n = $urandom_range(2, 12);
          for (int i = 0; i < n; i++) begin
            a = 16'($urandom_range(0, 16'h1FFF));
            ram_addrs.push_back(a);
            add_access(OpWrite, a, 8'($urandom()), 1'($urandom_range(0, 1)), drain && i == 0);
          end
          ram_addrs.shuffle();
          // read back through a random mirror
          foreach (ram_addrs[i])
            add_access(OpRead, ram_addrs[i] ^ 16'($urandom_range(0, 3) << 11),
                       8'($urandom()), 1'b0, 1'b0);
        end
        SeqPad: begin
          add_access(OpLoad, 16'($urandom()), 8'($urandom()), 1'b0, drain);
          add_access(OpLoad, 16'($urandom()), 8'($urandom()), 1'b1, 1'b0);
          add_access(OpWrite, AddrPad0, 8'($urandom()) | 8'h01, 1'b0, 1'b0);
          if ($urandom_range(0, 2) == 0) add_access(OpRead, AddrPad0, 8'h00, 1'b0, 1'b0);
          if ($urandom_range(0, 4) != 0)
            add_access(OpWrite, AddrPad0, 8'($urandom()) & 8'hFE, 1'b0, 1'b0);
          n = $urandom_range(4, 12);
          for (int i = 0; i < n; i++)
            add_access(OpRead, $urandom_range(0, 1) ? AddrPad1 : AddrPad0,
                       8'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
        end
        SeqNoise: begin
          n = $urandom_range(10, 30);
          for (int i = 0; i < n; i++) add_noise(drain && i == 0);
        end
        default: begin
          n = $urandom_range(0, 9);
          page = (n < 4) ? 8'($urandom_range(0, 8'h1F)) : (n < 6) ? 8'h40 : 8'($urandom());
          add_access(OpWrite, AddrDmaStart, page, 1'b0, drain);
          steps = (first_seq || $urandom_range(0, 1)) ? 256 : $urandom_range(1, 255);
          for (int i = 0; i < steps; i++) begin
            if ($urandom_range(0, 11) == 0) add_noise(1'b0);
            add_access(OpDma, 16'($urandom()), 8'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
          end
        end
      endcase
      first_seq = 1'b0;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample between edges so the driver and monitor updates have settled
    while (access_queue.size() != 0 || in_valid_i || n_accepted != n_checked)
      @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_bus_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_bus_results.size());
      n_errors++;
    end

    $display("checked %0d results: %0d reads (%0d pad), %0d writes, %0d button loads",
             n_checked, n_reads, n_pad_reads, n_writes, n_loads);
    $display("sprite dma: %0d starts, %0d completed, %0d byte steps; %0d errors",
             n_dma_starts, n_dma_done, n_dma_steps, n_errors);
    if (n_errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
